FILE: hw/rtl/indexed_shift_list_defines.svh
// Assertion macros for the indexed shift list
`ifndef INDEXED_SHIFT_LIST_DEFINES_SVH
`define INDEXED_SHIFT_LIST_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ISL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("isl assertion failed");
// next-cycle implication
`define ISL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("isl assertion failed");
`else
`define ISL_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define ISL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/isl_pkg.sv
package isl_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CAP_W  = 7;
    localparam int POS_W  = 7;

    typedef enum logic [2:0] {
        MODE_INSERT_AT    = 3'd0,
        MODE_APPEND       = 3'd1,
        MODE_REMOVE_AT    = 3'd2,
        MODE_REMOVE_FIRST = 3'd3,
        MODE_REMOVE_LAST  = 3'd4,
        MODE_READ_AT      = 3'd5,
        MODE_READ_LAST    = 3'd6,
        MODE_CLEAR        = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t            op;
        logic [CNT_W-1:0]    pos;
        logic [WORD_W-1:0]   word;
        logic [CNT_W-1:0]    rd_idx;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/isl_cell.sv
module isl_cell (
    input  logic                      aclk,
    input  logic [isl_pkg::CNT_W-1:0] cell_idx,
    input  isl_pkg::cell_ctrl_t       ctrl,
    input  logic [isl_pkg::WORD_W-1:0] left_word,
    input  logic [isl_pkg::WORD_W-1:0] right_word,
    output logic [isl_pkg::WORD_W-1:0] word,
    output logic [isl_pkg::WORD_W-1:0] rd_word
);
    import isl_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // shift up on insert past the slot, shift down on remove at/after it
    always_comb begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (cell_idx > ctrl.pos) begin
                    word_next = left_word;
                end else if (cell_idx == ctrl.pos) begin
                    word_next = ctrl.word;
                end
            end
            CELL_DEL: begin
                if (cell_idx >= ctrl.pos) begin
                    word_next = right_word;
                end
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    // masked read: only the addressed cell contributes to the OR bus
    assign rd_word = (cell_idx == ctrl.rd_idx) ? word_reg : '0;

endmodule

FILE: hw/rtl/indexed_shift_list.sv
// A request's result is on the m_ channel in the cycle after it is accepted.
// Throughput: one request per cycle while no result waits on a low m_ready;
// every cell of the chain updates in the same cycle, and reads go through a
// per-cell index compare and an OR bus. A request is taken while the result
// register is empty or being drained. Reset (aresetn low, synchronous): count 0,
// capacity 64, no result pending; stored words are not cleared.
module indexed_shift_list (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [isl_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_mode,
    input  logic [isl_pkg::POS_W-1:0]   s_position,
    input  logic signed [isl_pkg::WORD_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic signed [isl_pkg::WORD_W-1:0] m_read_word,
    output logic [isl_pkg::CNT_W-1:0]   m_count,
    output logic                        m_full_flag,
    output logic                        m_empty_flag
);
    import isl_pkg::*;

`include "indexed_shift_list_defines.svh"

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] rd_next;
    logic [CNT_W-1:0]  count_reg;
    logic              full_reg;
    logic              empty_reg;

    logic              accept;
    mode_t             mode;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  ins_pos;
    logic [CNT_W-1:0]  last_idx;
    logic              is_full;
    logic              is_empty;
    cell_op_t          op;
    cell_ctrl_t        ctrl;
    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_rd   [DEPTH];
    logic [WORD_W-1:0] rd_bus;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign mode    = mode_t'(s_mode);

    // capacity limited to the store depth
    assign cap_eff  = (CNT_W'(cap_reg) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);
    assign ins_pos  = (mode == MODE_APPEND) ? held_reg : CNT_W'(s_position);
    assign last_idx = held_reg - CNT_W'(1);
    assign is_full  = held_reg >= cap_eff;
    assign is_empty = held_reg == '0;

    // operation decode: status, new count, read word, cell command
    always_comb begin
        status_next = ST_OK;
        rd_next     = '0;
        held_next   = held_reg;
        op          = CELL_HOLD;
        case (mode)
            MODE_INSERT_AT, MODE_APPEND: begin
                if (ins_pos > held_reg) begin
                    status_next = ST_BAD_INDEX;
                end else if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    op        = CELL_INS;
                    held_next = held_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE_AT: begin
                if (CNT_W'(s_position) >= held_reg) begin
                    status_next = ST_BAD_INDEX;
                end else begin
                    op        = CELL_DEL;
                    held_next = last_idx;
                end
            end
            MODE_REMOVE_FIRST: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op        = CELL_DEL;
                    held_next = last_idx;
                end
            end
            MODE_REMOVE_LAST: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    held_next = last_idx;
                end
            end
            MODE_READ_AT: begin
                if (CNT_W'(s_position) >= held_reg) begin
                    status_next = ST_BAD_INDEX;
                    rd_next     = '1;
                end else begin
                    rd_next = rd_bus;
                end
            end
            MODE_READ_LAST: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                    rd_next     = '1;
                end else begin
                    rd_next = rd_bus;
                end
            end
            default: begin
                held_next = '0;
            end
        endcase
    end

    // command broadcast to the chain; remove-first is remove at slot zero
    always_comb begin
        ctrl.op     = accept ? op : CELL_HOLD;
        ctrl.pos    = (mode == MODE_REMOVE_FIRST) ? '0 : ins_pos;
        ctrl.word   = s_value;
        ctrl.rd_idx = (mode == MODE_READ_LAST) ? last_idx : CNT_W'(s_position);
    end

    // row of cells, each fed by its neighbors; the end cells see zero past the row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (gi == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[gi+1];
        end

        isl_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (CNT_W'(gi)),
            .ctrl       (ctrl),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[gi]),
            .rd_word    (cell_rd[gi])
        );
    end

    // OR bus over the masked cell outputs
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_W'(DEPTH);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (accept) begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            count_reg  <= held_next;
            full_reg   <= held_next >= cap_eff;
            empty_reg  <= held_next == '0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_read_word  = rd_reg;
    assign m_count      = count_reg;
    assign m_full_flag  = full_reg;
    assign m_empty_flag = empty_reg;

    // checks
    `ISL_ASSERT_NOW(a_held_range, aclk, aresetn, 1'b1, held_reg <= CNT_W'(DEPTH))
    `ISL_ASSERT_NEXT(a_result_follows, aclk, aresetn, accept, out_valid_reg)
    `ISL_ASSERT_NOW(a_no_overrun, aclk, aresetn, out_valid_reg && !m_ready, !s_ready)
    `ISL_ASSERT_NOW(a_full_status_flag, aclk, aresetn, out_valid_reg && status_reg == ST_FULL, full_reg)

endmodule
